[hdl/stis_pkg.sv]
`timescale 1ns / 1ps

package stis_pkg;

	localparam int NUM_SITES    = 64;
	localparam int MAX_SEGMENTS = 64;
	localparam int SEG_DEPTH    = NUM_SITES * MAX_SEGMENTS;
	localparam int ADDR_W       = $clog2(SEG_DEPTH);

	localparam int CMD_W  = 2;
	localparam int SITE_W = 6;
	localparam int IDX_W  = 6;
	localparam int CNT_W  = 7;
	localparam int TIME_W = 32;
	localparam int LU_W   = CNT_W + 1;

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FIND  = 2'd2;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_COUNT = 2'd1;
	localparam logic [1:0] OP_FIND  = 2'd2;
	localparam logic [1:0] OP_MISS  = 2'd3;

	typedef struct packed {
		logic [1:0]              op;
		logic [SITE_W-1:0]       site;
		logic [IDX_W-1:0]        slot;
		logic [CNT_W-1:0]        count;
		logic signed [TIME_W-1:0] time_a;
		logic signed [TIME_W-1:0] time_b;
		logic                    has_begin;
		logic                    has_end;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	typedef struct packed {
		logic signed [TIME_W-1:0] begin_time;
		logic signed [TIME_W-1:0] end_time;
		logic                     has_begin;
		logic                     has_end;
	} seg_t;

endpackage

[hdl/stis_req_if.sv]
`timescale 1ns / 1ps

interface stis_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         command;
	logic [5:0]         site;
	logic [5:0]         slot;
	logic [6:0]         segment_count;
	logic signed [31:0] query_time;
	logic signed [31:0] begin_time;
	logic               has_begin;
	logic signed [31:0] end_time;
	logic               has_end;

	modport source (
		output valid, command, site, slot, segment_count, query_time,
		       begin_time, has_begin, end_time, has_end,
		input  ready
	);
	modport sink (
		input  valid, command, site, slot, segment_count, query_time,
		       begin_time, has_begin, end_time, has_end,
		output ready
	);
endinterface

[hdl/stis_rsp_if.sv]
`timescale 1ns / 1ps

interface stis_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] segment_index;
	logic       found;

	modport source (
		output valid, segment_index, found,
		input  ready
	);
	modport sink (
		input  valid, segment_index, found,
		output ready
	);
endinterface

[hdl/segment_time_interval_search_unit.sv]
`timescale 1ns / 1ps

// Segment time interval search.
// req (sink): one command per transfer. Segment writes and count writes
// produce no result; every find produces exactly one transfer on rsp
// (source) with segment_index and found, in command order.
// Commands are classified on entry and held in a two-entry queue; the
// search engine drains it one command a cycle for writes while no find is busy.
// A find runs a binary search over the site's segments: the site count is
// read first, then each probe uses the segment memory read port, at most
// seven probes for 64 segments. The engine takes the next command only once
// the find's result is loaded into the output register.
// Segment memory has no reset; per-site counts read as zero until written,
// so every site starts empty. Reset empties the queue and drops any pending
// result.
// When rsp stalls the result is held in its output register; commands are
// still accepted until the queue fills, then req.ready drops.
module segment_time_interval_search_unit
	import stis_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	stis_req_if.sink   req,
	stis_rsp_if.source rsp
);

	q_wr_t     q_push;
	q_status_t q_status;
	q_item_t   head;
	logic      pop;

	stis_front u_front (
		.req      (req),
		.q_status (q_status),
		.q_push   (q_push)
	);

	stis_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_push   (q_push),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	stis_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_status (q_status),
		.pop      (pop),
		.rsp      (rsp)
	);

endmodule

[hdl/stis_front.sv]
`timescale 1ns / 1ps

module stis_front
	import stis_pkg::*;
(
	stis_req_if.sink req,
	input  q_status_t q_status,
	output q_wr_t     q_push
);

	logic site_ok;
	logic slot_ok;
	logic keep;
	logic [1:0] op;
	logic [CNT_W-1:0] cnt_sat;

	assign req.ready = !q_status.full;

	assign site_ok = 32'(req.site) < NUM_SITES;
	assign slot_ok = 32'(req.slot) < MAX_SEGMENTS;
	assign cnt_sat = (32'(req.segment_count) > MAX_SEGMENTS) ?
		CNT_W'(MAX_SEGMENTS) : req.segment_count;

	always_comb begin
		keep = 1'b0;
		op   = OP_MISS;
		unique case (req.command)
			CMD_WRITE: begin
				op   = OP_WRITE;
				keep = site_ok && slot_ok;
			end
			CMD_COUNT: begin
				op   = OP_COUNT;
				keep = site_ok;
			end
			CMD_FIND: begin
				op   = site_ok ? OP_FIND : OP_MISS;
				keep = 1'b1;
			end
			default: begin
				op   = OP_MISS;
				keep = 1'b0;
			end
		endcase
	end

	always_comb begin
		q_push.valid          = req.valid && req.ready && keep;
		q_push.item.op        = op;
		q_push.item.site      = req.site;
		q_push.item.slot      = req.slot;
		q_push.item.count     = cnt_sat;
		q_push.item.time_a    = (req.command == CMD_FIND) ? req.query_time : req.begin_time;
		q_push.item.time_b    = req.end_time;
		q_push.item.has_begin = req.has_begin;
		q_push.item.has_end   = req.has_end;
	end

endmodule

[hdl/stis_queue.sv]
`timescale 1ns / 1ps

module stis_queue
	import stis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_wr_t     q_push,
	input  logic      pop,
	output q_item_t   head,
	output q_status_t q_status
);

	q_item_t              entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   fill_q;
	logic                 do_push;
	logic                 do_pop;

	assign q_status.full  = fill_q == Q_CNT_W'(Q_DEPTH);
	assign q_status.empty = fill_q == '0;
	assign do_push = q_push.valid && !q_status.full;
	assign do_pop  = pop && !q_status.empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			entry_q[wr_ptr_q] <= q_push.item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (32'(wr_ptr_q) == Q_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (32'(rd_ptr_q) == Q_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				fill_q <= fill_q + 1'b1;
			else if (!do_push && do_pop)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

[hdl/stis_back.sv]
`timescale 1ns / 1ps

module stis_back
	import stis_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  q_item_t   head,
	input  q_status_t q_status,
	output logic      pop,
	stis_rsp_if.source rsp
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_COUNT = 2'd1;
	localparam logic [1:0] ST_PROBE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_n;

	seg_t             seg_mem [SEG_DEPTH];
	seg_t             seg_rd_q;
	logic             seg_we;
	logic             seg_re;
	logic [ADDR_W-1:0] seg_wa;
	logic [ADDR_W-1:0] seg_ra;
	seg_t             seg_wd;

	logic [CNT_W-1:0] cnt_mem [NUM_SITES];
	logic             cnt_vld_q [NUM_SITES];
	logic [CNT_W-1:0] cnt_rd_q;
	logic             cnt_vld_rd_q;
	logic             cnt_we;
	logic             cnt_re;
	logic [CNT_W-1:0] cnt_cur;

	logic [SITE_W-1:0]         site_q;
	logic signed [TIME_W-1:0]  t_q;
	logic signed [LU_W-1:0]    lo_q;
	logic signed [LU_W-1:0]    up_q;
	logic signed [LU_W-1:0]    lo_n;
	logic signed [LU_W-1:0]    up_n;
	logic signed [LU_W-1:0]    jx;
	logic signed [LU_W:0]      sum_n;
	logic [IDX_W-1:0]          j_q;
	logic [IDX_W-1:0]          j_n;
	logic                      empty_n;
	logic                      hit;
	logic                      go_low;

	logic [IDX_W-1:0] res_idx_q;
	logic             res_found_q;
	logic             rsp_valid_q;
	logic [IDX_W-1:0] rsp_idx_q;
	logic             rsp_found_q;
	logic             rsp_load;

	assign rsp.valid         = rsp_valid_q;
	assign rsp.segment_index = rsp_idx_q;
	assign rsp.found         = rsp_found_q;

	assign pop      = (state_q == ST_IDLE) && !q_status.empty;
	assign seg_we   = pop && (head.op == OP_WRITE);
	assign cnt_we   = pop && (head.op == OP_COUNT);
	assign cnt_re   = pop && (head.op == OP_FIND);
	assign rsp_load = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	assign seg_wa = ADDR_W'(32'(head.site) * MAX_SEGMENTS + 32'(head.slot));
	assign seg_wd = '{begin_time: head.time_a, end_time: head.time_b,
		has_begin: head.has_begin, has_end: head.has_end};

	assign cnt_cur = cnt_vld_rd_q ? cnt_rd_q : '0;
	assign jx      = $signed({{(LU_W-IDX_W){1'b0}}, j_q});

	assign hit = (!seg_rd_q.has_end || ($signed(seg_rd_q.end_time) >= t_q)) &&
		(!seg_rd_q.has_begin || ($signed(seg_rd_q.begin_time) < t_q));
	assign go_low = !seg_rd_q.has_end || ($signed(seg_rd_q.end_time) > t_q);

	always_comb begin
		lo_n = lo_q;
		up_n = up_q;
		case (state_q)
			ST_COUNT: begin
				lo_n = '0;
				up_n = $signed({1'b0, cnt_cur}) - LU_W'(1);
			end
			ST_PROBE: begin
				if (go_low)
					up_n = jx - LU_W'(1);
				else
					lo_n = jx + LU_W'(1);
			end
			default: begin
				lo_n = lo_q;
				up_n = up_q;
			end
		endcase
		sum_n   = {lo_n[LU_W-1], lo_n} + {up_n[LU_W-1], up_n};
		j_n     = sum_n[IDX_W:1];
		empty_n = lo_n > up_n;
	end

	assign seg_re = ((state_q == ST_COUNT) || ((state_q == ST_PROBE) && !hit)) && !empty_n;
	assign seg_ra = ADDR_W'(32'(site_q) * MAX_SEGMENTS + 32'(j_n));

	always_ff @(posedge clk) begin
		if (seg_we)
			seg_mem[seg_wa] <= seg_wd;
		if (seg_re)
			seg_rd_q <= seg_mem[seg_ra];
	end

	always_ff @(posedge clk) begin
		if (cnt_we)
			cnt_mem[head.site] <= head.count;
		if (cnt_re)
			cnt_rd_q <= cnt_mem[head.site];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SITES; i++)
				cnt_vld_q[i] <= 1'b0;
			cnt_vld_rd_q <= 1'b0;
		end else begin
			if (cnt_we)
				cnt_vld_q[head.site] <= 1'b1;
			if (cnt_re)
				cnt_vld_rd_q <= cnt_vld_q[head.site];
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && (head.op == OP_FIND))
					state_n = ST_COUNT;
				else if (pop && (head.op == OP_MISS))
					state_n = ST_DONE;
			end
			ST_COUNT: begin
				state_n = empty_n ? ST_DONE : ST_PROBE;
			end
			ST_PROBE: begin
				if (hit || empty_n)
					state_n = ST_DONE;
			end
			ST_DONE: begin
				if (rsp_load)
					state_n = ST_IDLE;
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			site_q <= head.site;
			t_q    <= head.time_a;
		end
		if ((state_q == ST_COUNT) || (state_q == ST_PROBE)) begin
			lo_q <= lo_n;
			up_q <= up_n;
			j_q  <= j_n;
		end
		if (pop && (head.op == OP_MISS)) begin
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
		end else if ((state_q == ST_PROBE) && hit) begin
			res_idx_q   <= j_q;
			res_found_q <= 1'b1;
		end else if (((state_q == ST_COUNT) || (state_q == ST_PROBE)) && empty_n) begin
			res_idx_q   <= '0;
			res_found_q <= 1'b0;
		end
		if (rsp_load) begin
			rsp_idx_q   <= res_idx_q;
			rsp_found_q <= res_found_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

[hdl/stis_checker.sv]
`timescale 1ns / 1ps

module stis_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [5:0] rsp_segment_index,
	input logic       rsp_found
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("rsp valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_segment_index) && $stable(rsp_found))
		else $error("rsp payload changed while stalled");

	a_miss_index: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_found |-> rsp_segment_index == 6'd0)
		else $error("not-found result carries a nonzero index");

	a_reset_clean: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> req_ready && !rsp_valid)
		else $error("block not empty after reset release");

endmodule

bind segment_time_interval_search_unit stis_checker u_stis_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_segment_index (rsp.segment_index),
	.rsp_found         (rsp.found)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import stis_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
	localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;
	localparam int STALL_LIMIT = 5000;
	localparam int ITEM_TARGET = 1700;

	typedef struct packed {
		logic [IDX_W-1:0] segment_index;
		logic             found;
	} hit_t;

	typedef struct {
		logic [CMD_W-1:0]   command;
		logic [SITE_W-1:0]  site;
		logic [IDX_W-1:0]   slot;
		logic [CNT_W-1:0]   segment_count;
		logic signed [31:0] query_time;
		logic signed [31:0] begin_time;
		logic               has_begin;
		logic signed [31:0] end_time;
		logic               has_end;
		bit                 typed;
		hit_t               want;
	} req_t;

	logic clk = 1'b0;
	logic arst_n;

	stis_req_if req ();
	stis_rsp_if rsp ();

	segment_time_interval_search_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic signed [31:0] seg_begin [NUM_SITES][MAX_SEGMENTS];
	logic signed [31:0] seg_end   [NUM_SITES][MAX_SEGMENTS];
	bit                 seg_hb    [NUM_SITES][MAX_SEGMENTS];
	bit                 seg_he    [NUM_SITES][MAX_SEGMENTS];
	bit                 seg_known [NUM_SITES][MAX_SEGMENTS];
	int                 site_len  [NUM_SITES];

	hit_t pending_hits[$];
	req_t dir_tab[$];
	int   sent_items = 0;
	int   errors = 0;
	int   quiet_cycles = 0;
	hit_t got_hit;
	hit_t want_hit;
	logic calm;

	assign calm = (sent_items >= 700) && (sent_items < 1000);

	function automatic hit_t lookup_segment(input int s, input logic signed [31:0] t);
		hit_t h;
		int   lo;
		int   up;
		int   j;
		bit   end_ok;
		bit   beg_ok;
		h = '0;
		lo = 0;
		up = site_len[s] - 1;
		while (lo <= up && !h.found) begin
			j = (lo + up) / 2;
			end_ok = !seg_he[s][j] || (seg_end[s][j] >= t);
			beg_ok = !seg_hb[s][j] || (seg_begin[s][j] < t);
			if (end_ok && beg_ok) begin
				h.segment_index = IDX_W'(j);
				h.found = 1'b1;
			end else if (!seg_he[s][j] || (seg_end[s][j] > t)) begin
				up = j - 1;
			end else begin
				lo = j + 1;
			end
		end
		return h;
	endfunction

	function automatic int written_prefix(input int s);
		int k;
		k = 0;
		while (k < MAX_SEGMENTS && seg_known[s][k])
			k++;
		return k;
	endfunction

	function automatic void apply_req(input req_t r);
		case (r.command)
			CMD_WRITE: begin
				seg_begin[r.site][r.slot] = r.begin_time;
				seg_end[r.site][r.slot]   = r.end_time;
				seg_hb[r.site][r.slot]    = r.has_begin;
				seg_he[r.site][r.slot]    = r.has_end;
				seg_known[r.site][r.slot] = 1'b1;
			end
			CMD_COUNT: begin
				site_len[r.site] = (r.segment_count > MAX_SEGMENTS) ? MAX_SEGMENTS
					: int'(r.segment_count);
			end
			CMD_FIND: begin
				pending_hits.push_back(r.typed ? r.want : lookup_segment(r.site, r.query_time));
			end
			default: ;
		endcase
		if (r.command != CMD_SPARE)
			sent_items++;
	endfunction

	function automatic req_t make_req(input logic [CMD_W-1:0] cmd, input logic [SITE_W-1:0] s);
		req_t r;
		r.command       = cmd;
		r.site          = s;
		r.slot          = IDX_W'($urandom);
		r.segment_count = CNT_W'($urandom);
		r.query_time    = $urandom;
		r.begin_time    = $urandom;
		r.has_begin     = 1'($urandom_range(0, 1));
		r.end_time      = $urandom;
		r.has_end       = 1'($urandom_range(0, 1));
		r.typed         = 1'b0;
		r.want          = '0;
		return r;
	endfunction

	function automatic req_t dir_row(input logic [CMD_W-1:0] cmd, input logic [SITE_W-1:0] s,
			input logic [IDX_W-1:0] sl, input logic [CNT_W-1:0] cnt,
			input logic signed [31:0] qt, input logic signed [31:0] bt, input logic hb,
			input logic signed [31:0] et, input logic he,
			input bit typed, input logic [IDX_W-1:0] idx, input logic fnd);
		req_t r;
		r.command       = cmd;
		r.site          = s;
		r.slot          = sl;
		r.segment_count = cnt;
		r.query_time    = qt;
		r.begin_time    = bt;
		r.has_begin     = hb;
		r.end_time      = et;
		r.has_end       = he;
		r.typed         = typed;
		r.want.segment_index = idx;
		r.want.found    = fnd;
		return r;
	endfunction

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return T_MAX;
		if (v < -64'sd2147483648)
			return T_MIN;
		return v[31:0];
	endfunction

	function automatic void note_mismatch(input string what, input hit_t want, input hit_t got);
		errors++;
		if (errors <= 10)
			$display("%0t %s: expected index %0d found %0d, got index %0d found %0d",
				$realtime, what, want.segment_index, want.found,
				got.segment_index, got.found);
	endfunction

	task automatic push_req(input req_t r);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 15) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid         <= 1'b1;
		req.command       <= r.command;
		req.site          <= r.site;
		req.slot          <= r.slot;
		req.segment_count <= r.segment_count;
		req.query_time    <= r.query_time;
		req.begin_time    <= r.begin_time;
		req.has_begin     <= r.has_begin;
		req.end_time      <= r.end_time;
		req.has_end       <= r.has_end;
		do @(posedge clk); while (!req.ready);
		apply_req(r);
	endtask

	always @(negedge clk)
		rsp.ready <= calm || ($urandom_range(0, 99) >= 15);

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			got_hit.segment_index = rsp.segment_index;
			got_hit.found = rsp.found;
			if (pending_hits.size() == 0) begin
				note_mismatch("unexpected result", '0, got_hit);
			end else begin
				want_hit = pending_hits.pop_front();
				if (got_hit.segment_index !== want_hit.segment_index ||
						got_hit.found !== want_hit.found)
					note_mismatch("result mismatch", want_hit, got_hit);
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		req_t        r;
		int          pick;
		int          n;
		int          m;
		int          k;
		int          j;
		int          lim;
		bit          wide;
		bit          rev;
		longint      bnd [65];
		longint      gap_max;
		longint      span;
		longint      v;
		logic [SITE_W-1:0] s;

		arst_n            = 1'b0;
		req.valid         = 1'b0;
		req.command       = CMD_WRITE;
		req.site          = '0;
		req.slot          = '0;
		req.segment_count = '0;
		req.query_time    = '0;
		req.begin_time    = '0;
		req.has_begin     = 1'b0;
		req.end_time      = '0;
		req.has_end       = 1'b0;
		rsp.ready         = 1'b0;

		dir_tab.push_back(dir_row(CMD_FIND, 6'd0, 6'd0, 7'd0, 32'sd0, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b1, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd63, 6'd0, 7'd0, T_MAX, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b1, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_SPARE, 6'd63, 6'd63, 7'd127, T_MAX, T_MIN, 1'b1,
			T_MAX, 1'b1, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_WRITE, 6'd63, 6'd0, 7'd0, 32'sd0, T_MIN, 1'b1,
			T_MAX, 1'b1, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_COUNT, 6'd63, 6'd0, 7'd1, 32'sd0, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd63, 6'd0, 7'd0, T_MIN, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b1, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd63, 6'd0, 7'd0, T_MAX, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b1, 6'd0, 1'b1));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd63, 6'd0, 7'd0, 32'sd0, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_WRITE, 6'd1, 6'd0, 7'd0, 32'sd0, 32'sd5, 1'b0,
			-32'sd5, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_COUNT, 6'd1, 6'd0, 7'd1, 32'sd0, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd1, 6'd0, 7'd0, T_MIN, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b1, 6'd0, 1'b1));
		dir_tab.push_back(dir_row(CMD_WRITE, 6'd2, 6'd0, 7'd0, 32'sd0, 32'sd10, 1'b1,
			32'sd20, 1'b1, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_WRITE, 6'd2, 6'd1, 7'd0, 32'sd0, 32'sd20, 1'b1,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_COUNT, 6'd2, 6'd0, 7'd2, 32'sd0, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd2, 6'd0, 7'd0, 32'sd15, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd2, 6'd0, 7'd0, 32'sd25, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd2, 6'd0, 7'd0, 32'sd10, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd2, 6'd0, 7'd0, 32'sd20, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_WRITE, 6'd2, 6'd63, 7'd0, 32'sd0, T_MAX, 1'b1,
			T_MIN, 1'b1, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_COUNT, 6'd3, 6'd0, 7'd0, 32'sd0, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd3, 6'd0, 7'd0, 32'sd5, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b1, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_COUNT, 6'd2, 6'd0, 7'd0, 32'sd0, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd2, 6'd0, 7'd0, 32'sd15, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b1, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_COUNT, 6'd2, 6'd0, 7'd2, 32'sd0, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));
		dir_tab.push_back(dir_row(CMD_FIND, 6'd2, 6'd0, 7'd0, T_MIN, 32'sd0, 1'b0,
			32'sd0, 1'b0, 1'b0, 6'd0, 1'b0));

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i])
			push_req(dir_tab[i]);

		while (sent_items < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				s = SITE_W'($urandom);
				m = $urandom_range(0, 99);
				n = (m < 80) ? $urandom_range(1, 8) : (m < 95) ? $urandom_range(9, 32)
					: MAX_SEGMENTS;
				wide = $urandom_range(0, 1);
				if (wide) begin
					gap_max = 64'sd4294967295 / (n + 1);
					bnd[0] = -64'sd2147483648 + longint'($urandom_range(0, 32'(gap_max - 1)));
				end else begin
					gap_max = 4;
					bnd[0] = longint'($signed($urandom));
					if (bnd[0] > 64'sd2147483647 - 300)
						bnd[0] = 64'sd2147483647 - 300;
				end
				for (k = 0; k < n; k++)
					bnd[k + 1] = bnd[k] + longint'($urandom_range(1, 32'(gap_max)));
				rev = ($urandom_range(0, 3) == 0);
				for (k = 0; k < n; k++) begin
					j = rev ? n - 1 - k : k;
					r = make_req(CMD_WRITE, s);
					r.slot = IDX_W'(j);
					r.begin_time = clip32(bnd[j]);
					if ($urandom_range(0, 4) == 0)
						r.end_time = clip32(bnd[j] +
							longint'($urandom_range(0, 32'(bnd[j + 1] - bnd[j]))));
					else
						r.end_time = clip32(bnd[j + 1]);
					r.has_begin = !((j == 0 && $urandom_range(0, 2) == 0) ||
						$urandom_range(0, 19) == 0);
					r.has_end = !((j == n - 1 && $urandom_range(0, 2) == 0) ||
						$urandom_range(0, 19) == 0);
					push_req(r);
				end
				r = make_req(CMD_COUNT, s);
				if (n == MAX_SEGMENTS)
					r.segment_count = CNT_W'($urandom_range(MAX_SEGMENTS, 127));
				else if ($urandom_range(0, 9) == 0)
					r.segment_count = CNT_W'($urandom_range(0, n));
				else
					r.segment_count = CNT_W'(n);
				push_req(r);
				m = $urandom_range(2, 10);
				for (k = 0; k < m; k++) begin
					r = make_req(CMD_FIND, s);
					pick = $urandom_range(0, 99);
					if (pick < 50) begin
						v = longint'($urandom_range(0, 2));
						r.query_time = clip32(bnd[$urandom_range(0, n)] + v - 1);
					end else if (pick < 75) begin
						span = bnd[n] - bnd[0];
						if (span > 64'sd4294967291)
							span = 64'sd4294967291;
						v = longint'($urandom_range(0, 32'(span + 4)));
						r.query_time = clip32(bnd[0] - 2 + v);
					end else if (pick >= 90) begin
						r.query_time = $urandom_range(0, 1) ? T_MIN : T_MAX;
					end
					push_req(r);
				end
			end else if (pick < 80) begin
				m = $urandom_range(1, 4);
				for (k = 0; k < m; k++)
					push_req(make_req(CMD_WRITE, SITE_W'($urandom)));
			end else if (pick < 92) begin
				m = $urandom_range(1, 4);
				for (k = 0; k < m; k++)
					push_req(make_req(CMD_FIND, SITE_W'($urandom)));
			end else if (pick < 97) begin
				r = make_req(CMD_COUNT, SITE_W'($urandom));
				lim = written_prefix(r.site);
				if (((r.segment_count > MAX_SEGMENTS) ? MAX_SEGMENTS
						: int'(r.segment_count)) > lim)
					r.segment_count = CNT_W'(lim);
				push_req(r);
			end else begin
				push_req(make_req(CMD_SPARE, SITE_W'($urandom)));
			end
		end

		@(negedge clk);
		req.valid <= 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
